// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// implication checked in the same cycle
`define S3_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication checked in the next cycle
`define S3_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define S3_ASSERT_SAME(lbl, ante, cons)
`define S3_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/s3conv_pkg.sv =====
`timescale 1ns / 1ps
package s3conv_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int IMG_W_W    = 12;
   localparam int ROW_W      = 16;
   localparam int PIX_W      = 16;
   localparam int COEF_W     = 16;
   localparam int HV_W       = 20;
   localparam int PROD_W     = HV_W + COEF_W;
   localparam int ACC_W      = PROD_W + 2;
   localparam int FRAC_W     = 14;
   localparam int SHR_W      = ACC_W - FRAC_W;
   localparam int TAP_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [IMG_W_W-1:0] IMG_W_MAX = IMG_W_W'(MAX_WIDTH);

   localparam logic [TAP_W-1:0] TAP_LEFT   = 2'd0;
   localparam logic [TAP_W-1:0] TAP_CENTER = 2'd1;
   localparam logic [TAP_W-1:0] TAP_LAST   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_LEFT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CENTER  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_RIGHT   = 3'd4;

   localparam logic [IMG_W_W-1:0]       IMAGE_WIDTH_RESET  = 12'd64;
   localparam logic [ROW_W-1:0]         IMAGE_HEIGHT_RESET = 16'd64;
   localparam logic signed [COEF_W-1:0] COEF_LEFT_RESET    = 16'sd4096;
   localparam logic signed [COEF_W-1:0] COEF_CENTER_RESET  = 16'sd8192;
   localparam logic signed [COEF_W-1:0] COEF_RIGHT_RESET   = 16'sd4096;

   // round half up before the shift
   localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(2 ** (FRAC_W - 1));

   localparam logic signed [SHR_W-1:0] HV_MAX  = SHR_W'(2 ** (HV_W - 1) - 1);
   localparam logic signed [SHR_W-1:0] HV_MIN  = -SHR_W'(2 ** (HV_W - 1));
   localparam logic signed [SHR_W-1:0] PIX_MAX = SHR_W'(2 ** (PIX_W - 1) - 1);
   localparam logic signed [SHR_W-1:0] PIX_MIN = -SHR_W'(2 ** (PIX_W - 1));

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HLOAD,
      ST_MAC,
      ST_ACC,
      ST_HSAVE,
      ST_VLOAD,
      ST_VOUT,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      OP_H_SINGLE,
      OP_H_INNER,
      OP_H_EDGE,
      OP_V_MID,
      OP_V_LAST,
      OP_V_ONE
   } op_mode_type;

   typedef struct packed {
      logic [IMG_W_W-1:0]       image_width;
      logic [ROW_W-1:0]         image_height;
      logic signed [COEF_W-1:0] coef_left;
      logic signed [COEF_W-1:0] coef_center;
      logic signed [COEF_W-1:0] coef_right;
   } cfg_type;

   typedef struct packed {
      logic              capture;
      logic              load_h;
      logic              load_v;
      logic              mac;
      logic [TAP_W-1:0]  tap;
      logic              acc_last;
      logic              save_h;
      logic              out_load;
      logic              out_last;
      logic              out_frame;
      logic              finish;
      logic              second;
      op_mode_type       mode;
   } dp_cmd_type;

   typedef struct packed {
      logic col_zero;
      logic row_end;
      logic last_row;
      logic row_nonzero;
      logic out_free;
   } dp_status_type;

   function automatic logic signed [HV_W-1:0] sat_h(input logic signed [ACC_W-1:0] acc);
      logic signed [SHR_W-1:0] q;
      q = SHR_W'(acc >>> FRAC_W);
      if (q > HV_MAX) begin
         sat_h = HV_MAX[HV_W-1:0];
      end else if (q < HV_MIN) begin
         sat_h = HV_MIN[HV_W-1:0];
      end else begin
         sat_h = q[HV_W-1:0];
      end
   endfunction

   function automatic logic signed [PIX_W-1:0] sat_v(input logic signed [ACC_W-1:0] acc);
      logic signed [SHR_W-1:0] q;
      q = SHR_W'(acc >>> FRAC_W);
      if (q > PIX_MAX) begin
         sat_v = PIX_MAX[PIX_W-1:0];
      end else if (q < PIX_MIN) begin
         sat_v = PIX_MIN[PIX_W-1:0];
      end else begin
         sat_v = q[PIX_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/s3conv_regs.sv =====
`timescale 1ns / 1ps
module s3conv_regs (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [s3conv_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [s3conv_pkg::CSR_DATA_W-1:0]     csr_data,
   output s3conv_pkg::cfg_type                   cfg
);

   s3conv_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            s3conv_pkg::CSR_IMAGE_WIDTH: begin
               cfg_in.image_width = csr_data[s3conv_pkg::IMG_W_W-1:0];
            end
            s3conv_pkg::CSR_IMAGE_HEIGHT: begin
               cfg_in.image_height = csr_data[s3conv_pkg::ROW_W-1:0];
            end
            s3conv_pkg::CSR_COEF_LEFT: begin
               cfg_in.coef_left = csr_data[s3conv_pkg::COEF_W-1:0];
            end
            s3conv_pkg::CSR_COEF_CENTER: begin
               cfg_in.coef_center = csr_data[s3conv_pkg::COEF_W-1:0];
            end
            s3conv_pkg::CSR_COEF_RIGHT: begin
               cfg_in.coef_right = csr_data[s3conv_pkg::COEF_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= s3conv_pkg::IMAGE_WIDTH_RESET;
         cfg_ff.image_height <= s3conv_pkg::IMAGE_HEIGHT_RESET;
         cfg_ff.coef_left    <= s3conv_pkg::COEF_LEFT_RESET;
         cfg_ff.coef_center  <= s3conv_pkg::COEF_CENTER_RESET;
         cfg_ff.coef_right   <= s3conv_pkg::COEF_RIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/s3conv_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module s3conv_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  s3conv_pkg::dp_status_type status,
   output s3conv_pkg::dp_cmd_type    cmd
);

   s3conv_pkg::state_type            state_ff, state_in;
   logic [s3conv_pkg::TAP_W-1:0]     tap_ff, tap_in;
   logic                             second_ff, second_in;
   logic                             vidx_ff, vidx_in;
   logic                             vphase_ff, vphase_in;
   logic                             more_col, more_v, has_col, has_v;

   // second column only at the end of a row past column zero
   assign more_col = !second_ff && !status.col_zero && status.row_end;
   assign more_v   = status.row_nonzero && status.last_row && !vidx_ff;
   assign has_col  = !status.col_zero || status.row_end;
   assign has_v    = status.row_nonzero || status.last_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= s3conv_pkg::ST_IDLE;
         tap_ff    <= '0;
         second_ff <= 1'b0;
         vidx_ff   <= 1'b0;
         vphase_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tap_ff    <= tap_in;
         second_ff <= second_in;
         vidx_ff   <= vidx_in;
         vphase_ff <= vphase_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      tap_in    = '0;
      second_in = second_ff;
      vidx_in   = vidx_ff;
      vphase_in = vphase_ff;
      case (state_ff)
         s3conv_pkg::ST_IDLE: begin
            second_in = 1'b0;
            if (req_valid) begin
               state_in = has_col ? s3conv_pkg::ST_HLOAD : s3conv_pkg::ST_FINISH;
            end
         end
         s3conv_pkg::ST_HLOAD: begin
            vphase_in = 1'b0;
            state_in  = s3conv_pkg::ST_MAC;
         end
         s3conv_pkg::ST_MAC: begin
            if (tap_ff == s3conv_pkg::TAP_LAST) begin
               state_in = s3conv_pkg::ST_ACC;
            end else begin
               tap_in = tap_ff + s3conv_pkg::TAP_W'(1);
            end
         end
         s3conv_pkg::ST_ACC: begin
            state_in = vphase_ff ? s3conv_pkg::ST_VOUT : s3conv_pkg::ST_HSAVE;
         end
         s3conv_pkg::ST_HSAVE: begin
            vidx_in = 1'b0;
            if (has_v) begin
               state_in = s3conv_pkg::ST_VLOAD;
            end else if (more_col) begin
               second_in = 1'b1;
               state_in  = s3conv_pkg::ST_HLOAD;
            end else begin
               state_in = s3conv_pkg::ST_FINISH;
            end
         end
         s3conv_pkg::ST_VLOAD: begin
            vphase_in = 1'b1;
            state_in  = s3conv_pkg::ST_MAC;
         end
         s3conv_pkg::ST_VOUT: begin
            if (status.out_free) begin
               if (more_v) begin
                  vidx_in  = 1'b1;
                  state_in = s3conv_pkg::ST_VLOAD;
               end else if (more_col) begin
                  second_in = 1'b1;
                  state_in  = s3conv_pkg::ST_HLOAD;
               end else begin
                  state_in = s3conv_pkg::ST_FINISH;
               end
            end
         end
         s3conv_pkg::ST_FINISH: begin
            second_in = 1'b0;
            state_in  = s3conv_pkg::ST_IDLE;
         end
         default: begin
            state_in = s3conv_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      req_stall     = (state_ff != s3conv_pkg::ST_IDLE);
      cmd.tap       = tap_ff;
      cmd.second    = second_ff;
      cmd.out_last  = !more_v && !more_col;
      cmd.out_frame = !more_v && !more_col && status.row_end && status.last_row;
      if (state_ff == s3conv_pkg::ST_HLOAD) begin
         cmd.mode = status.col_zero ? s3conv_pkg::OP_H_SINGLE :
                    (second_ff ? s3conv_pkg::OP_H_EDGE : s3conv_pkg::OP_H_INNER);
      end else begin
         cmd.mode = status.row_nonzero ?
                    (vidx_ff ? s3conv_pkg::OP_V_LAST : s3conv_pkg::OP_V_MID) :
                    s3conv_pkg::OP_V_ONE;
      end
      case (state_ff)
         s3conv_pkg::ST_IDLE:   cmd.capture  = req_valid;
         s3conv_pkg::ST_HLOAD:  cmd.load_h   = 1'b1;
         s3conv_pkg::ST_MAC:    cmd.mac      = 1'b1;
         s3conv_pkg::ST_ACC:    cmd.acc_last = 1'b1;
         s3conv_pkg::ST_HSAVE:  cmd.save_h   = 1'b1;
         s3conv_pkg::ST_VLOAD:  cmd.load_v   = 1'b1;
         s3conv_pkg::ST_VOUT:   cmd.out_load = status.out_free;
         s3conv_pkg::ST_FINISH: cmd.finish   = 1'b1;
         default:               cmd.finish   = 1'b0;
      endcase
   end

   `S3_ASSERT_SAME(a_tap_idle_outside_mac, state_ff != s3conv_pkg::ST_MAC, tap_ff == '0)
   `S3_ASSERT_SAME(a_vout_in_v_phase, state_ff == s3conv_pkg::ST_VOUT, vphase_ff)
   `S3_ASSERT_SAME(a_second_col_starts_load, $rose(second_ff), state_ff == s3conv_pkg::ST_HLOAD)

endmodule

// ===== rtl/s3conv_dp.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module s3conv_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  s3conv_pkg::cfg_type                    cfg,
   input  s3conv_pkg::dp_cmd_type                 cmd,
   output s3conv_pkg::dp_status_type              status,
   input  logic signed [s3conv_pkg::PIX_W-1:0]    req_pixel_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [s3conv_pkg::PIX_W-1:0]    rsp_pixel_out,
   output logic [s3conv_pkg::COL_W-1:0]           rsp_out_col,
   output logic [s3conv_pkg::ROW_W-1:0]           rsp_out_row,
   output logic                                   rsp_last_of_run,
   output logic                                   rsp_frame_done
);

   localparam int COL_W  = s3conv_pkg::COL_W;
   localparam int ROW_W  = s3conv_pkg::ROW_W;
   localparam int PIX_W  = s3conv_pkg::PIX_W;
   localparam int HV_W   = s3conv_pkg::HV_W;
   localparam int IMG_W_W = s3conv_pkg::IMG_W_W;

   // frame position and row history
   logic [COL_W-1:0]                   col_count_ff;
   logic [ROW_W-1:0]                   row_count_ff;
   logic signed [PIX_W-1:0]            prev_ff, prev_prev_ff, pix_ff;
   logic                               newer_sel_ff;

   // line buffers, roles swap at every row end
   logic [HV_W-1:0]                    line0_ff [s3conv_pkg::MAX_WIDTH];
   logic [HV_W-1:0]                    line1_ff [s3conv_pkg::MAX_WIDTH];
   logic [HV_W-1:0]                    rd0_ff, rd1_ff;

   // shared multiply accumulate
   logic signed [HV_W-1:0]             opnd0_ff, opnd1_ff, opnd2_ff;
   logic signed [HV_W-1:0]             opnd0_in, opnd1_in, opnd2_in;
   logic signed [HV_W-1:0]             mul_a;
   logic signed [s3conv_pkg::COEF_W-1:0] mul_b;
   logic signed [s3conv_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [s3conv_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [HV_W-1:0]             hv_ff, hv_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [PIX_W-1:0]            rsp_pixel_ff;
   logic [COL_W-1:0]                   rsp_col_ff;
   logic [ROW_W-1:0]                   rsp_row_ff;
   logic                               rsp_last_ff, rsp_frame_ff;

   logic [IMG_W_W-1:0]                 width_eff;
   logic [ROW_W-1:0]                   height_eff;
   logic                               row_ge2;
   logic [COL_W-1:0]                   col_x;
   logic signed [HV_W-1:0]             p_ext, prev_ext, left_ext, a1, a2, up;

   always_comb begin
      if (cfg.image_width == '0) begin
         width_eff = IMG_W_W'(1);
      end else if (cfg.image_width > s3conv_pkg::IMG_W_MAX) begin
         width_eff = s3conv_pkg::IMG_W_MAX;
      end else begin
         width_eff = cfg.image_width;
      end
      height_eff = (cfg.image_height == '0) ? ROW_W'(1) : cfg.image_height;

      status.col_zero    = (col_count_ff == '0);
      status.row_end     = (IMG_W_W'(col_count_ff) + IMG_W_W'(1)) >= width_eff;
      status.last_row    = ((ROW_W + 1)'(row_count_ff) + (ROW_W + 1)'(1)) >=
                           (ROW_W + 1)'(height_eff);
      status.row_nonzero = (row_count_ff != '0);
      status.out_free    = !rsp_valid_ff || !rsp_stall;
      row_ge2            = (row_count_ff > ROW_W'(1));

      if (col_count_ff == '0) begin
         col_x = '0;
      end else if (cmd.second) begin
         col_x = col_count_ff;
      end else begin
         col_x = col_count_ff - COL_W'(1);
      end
   end

   always_comb begin
      p_ext    = HV_W'(pix_ff);
      prev_ext = HV_W'(prev_ff);
      left_ext = (col_count_ff == COL_W'(1)) ? HV_W'(prev_ff) : HV_W'(prev_prev_ff);
      a1       = newer_sel_ff ? rd1_ff : rd0_ff;
      a2       = newer_sel_ff ? rd0_ff : rd1_ff;
      up       = row_ge2 ? a2 : a1;
      opnd0_in = opnd0_ff;
      opnd1_in = opnd1_ff;
      opnd2_in = opnd2_ff;
      if (cmd.load_h || cmd.load_v) begin
         case (cmd.mode)
            s3conv_pkg::OP_H_SINGLE: begin
               opnd0_in = p_ext;    opnd1_in = p_ext;    opnd2_in = p_ext;
            end
            s3conv_pkg::OP_H_INNER: begin
               opnd0_in = left_ext; opnd1_in = prev_ext; opnd2_in = p_ext;
            end
            s3conv_pkg::OP_H_EDGE: begin
               opnd0_in = prev_ext; opnd1_in = p_ext;    opnd2_in = p_ext;
            end
            s3conv_pkg::OP_V_MID: begin
               opnd0_in = up;       opnd1_in = a1;       opnd2_in = hv_ff;
            end
            s3conv_pkg::OP_V_LAST: begin
               opnd0_in = a1;       opnd1_in = hv_ff;    opnd2_in = hv_ff;
            end
            s3conv_pkg::OP_V_ONE: begin
               opnd0_in = hv_ff;    opnd1_in = hv_ff;    opnd2_in = hv_ff;
            end
            default: begin
               opnd0_in = opnd0_ff; opnd1_in = opnd1_ff; opnd2_in = opnd2_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (cmd.tap)
         s3conv_pkg::TAP_LEFT: begin
            mul_a = opnd0_ff;
            mul_b = cfg.coef_left;
         end
         s3conv_pkg::TAP_CENTER: begin
            mul_a = opnd1_ff;
            mul_b = cfg.coef_center;
         end
         default: begin
            mul_a = opnd2_ff;
            mul_b = cfg.coef_right;
         end
      endcase
      prod_in = mul_a * mul_b;
      if (cmd.mac && (cmd.tap == s3conv_pkg::TAP_LEFT)) begin
         acc_in = s3conv_pkg::ACC_ROUND;
      end else if (cmd.mac || cmd.acc_last) begin
         acc_in = acc_ff + s3conv_pkg::ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
      hv_in        = s3conv_pkg::sat_h(acc_ff);
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_h) begin
         rd0_ff <= line0_ff[col_x];
      end
      if (cmd.save_h && newer_sel_ff) begin
         line0_ff[col_x] <= hv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_h) begin
         rd1_ff <= line1_ff[col_x];
      end
      if (cmd.save_h && !newer_sel_ff) begin
         line1_ff[col_x] <= hv_in;
      end
   end

   always_ff @(posedge clock) begin
      opnd0_ff <= opnd0_in;
      opnd1_ff <= opnd1_in;
      opnd2_ff <= opnd2_in;
      acc_ff   <= acc_in;
      if (cmd.mac) begin
         prod_ff <= prod_in;
      end
      if (cmd.save_h) begin
         hv_ff <= hv_in;
      end
      if (cmd.capture) begin
         pix_ff <= req_pixel_in;
      end
      if (cmd.out_load) begin
         rsp_pixel_ff <= s3conv_pkg::sat_v(acc_ff);
         rsp_col_ff   <= col_x;
         rsp_row_ff   <= (cmd.mode == s3conv_pkg::OP_V_MID) ?
                         row_count_ff - ROW_W'(1) : row_count_ff;
         rsp_last_ff  <= cmd.out_last;
         rsp_frame_ff <= cmd.out_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         prev_ff      <= '0;
         prev_prev_ff <= '0;
         newer_sel_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.finish) begin
            prev_prev_ff <= prev_ff;
            prev_ff      <= pix_ff;
            if (status.row_end) begin
               col_count_ff <= '0;
               newer_sel_ff <= !newer_sel_ff;
               row_count_ff <= status.last_row ? '0 : row_count_ff + ROW_W'(1);
            end else begin
               col_count_ff <= col_count_ff + COL_W'(1);
            end
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_out   = rsp_pixel_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_frame_done  = rsp_frame_ff;

   `S3_ASSERT_SAME(a_no_overwrite_held_item, cmd.out_load, !rsp_valid_ff || !rsp_stall)
   `S3_ASSERT_NEXT(a_row_end_wraps_col, cmd.finish && status.row_end, col_count_ff == '0)
   `S3_ASSERT_NEXT(a_stalled_item_held, rsp_valid_ff && rsp_stall, rsp_valid_ff)

endmodule

// ===== rtl/separable_3tap_convolution.sv =====
`timescale 1ns / 1ps
// Separable 3-tap filter over one frame of signed Q1.15 pixels in raster order, with edge
// samples repeated at the frame border; configure width, height and the three Q2.14 taps
// only while the block is idle. Items are processed one at a time through a single shared
// multiply-accumulate unit: an item runs a horizontal pass for each column that its
// pixel closes, zero, one or two, and a vertical pass for each of that column's zero to
// two results, and waits while the result output is stalled. req_stall is high for the
// whole of that work. Line buffers need no clearing after reset.
module separable_3tap_convolution (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [s3conv_pkg::PIX_W-1:0]    req_pixel_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [s3conv_pkg::PIX_W-1:0]    rsp_pixel_out,
   output logic [s3conv_pkg::COL_W-1:0]           rsp_out_col,
   output logic [s3conv_pkg::ROW_W-1:0]           rsp_out_row,
   output logic                                   rsp_last_of_run,
   output logic                                   rsp_frame_done,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [s3conv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [s3conv_pkg::CSR_DATA_W-1:0]      csr_data
);

   s3conv_pkg::cfg_type       cfg;
   s3conv_pkg::dp_cmd_type    cmd;
   s3conv_pkg::dp_status_type status;

   s3conv_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   s3conv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   s3conv_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .req_pixel_in    (req_pixel_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_row     (rsp_out_row),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_done  (rsp_frame_done)
   );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;

   localparam int     HV_W       = s3conv_pkg::HV_W;
   localparam int     PIX_W      = s3conv_pkg::PIX_W;
   localparam int     COL_W      = s3conv_pkg::COL_W;
   localparam int     ROW_W      = s3conv_pkg::ROW_W;
   localparam int     IMG_W_W    = s3conv_pkg::IMG_W_W;
   localparam int     COEF_W     = s3conv_pkg::COEF_W;
   localparam int     CSR_IDX_W  = s3conv_pkg::CSR_IDX_W;
   localparam int     CSR_DATA_W = s3conv_pkg::CSR_DATA_W;
   localparam int     MAX_WIDTH  = s3conv_pkg::MAX_WIDTH;
   localparam int     FRAC_W     = s3conv_pkg::FRAC_W;

   localparam int     SETTLE_CYCLES  = 64;
   localparam int     WATCHDOG_LIMIT = 2000;
   localparam int     RANDOM_PIXELS  = 240;
   localparam longint HSUM_LOW  = -(longint'(1) << (HV_W - 1));
   localparam longint HSUM_HIGH = (longint'(1) << (HV_W - 1)) - 1;
   localparam longint OUT_LOW   = -(longint'(1) << (PIX_W - 1));
   localparam longint OUT_HIGH  = (longint'(1) << (PIX_W - 1)) - 1;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURST} stall_mode_type;
   typedef enum int {PIX_FULL, PIX_SMALL, PIX_EXTREME} pixel_style_type;

   typedef struct packed {
      logic signed [PIX_W-1:0] pixel;
      logic [COL_W-1:0]        col;
      logic [ROW_W-1:0]        row;
      logic                    last;
      logic                    frame;
   } filtered_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid    = 1'b0;
   logic                     req_stall;
   logic signed [PIX_W-1:0]  req_pixel_in = '0;
   logic                     rsp_valid;
   logic                     rsp_stall    = 1'b0;
   logic signed [PIX_W-1:0]  rsp_pixel_out;
   logic [COL_W-1:0]         rsp_out_col;
   logic [ROW_W-1:0]         rsp_out_row;
   logic                     rsp_last_of_run;
   logic                     rsp_frame_done;
   logic                     csr_valid    = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index    = '0;
   logic [CSR_DATA_W-1:0]    csr_data     = '0;

   filtered_type expected_pixels[$];

   logic [IMG_W_W-1:0]       cfg_width;
   logic [ROW_W-1:0]         cfg_height;
   logic signed [COEF_W-1:0] cfg_left, cfg_center, cfg_right;
   int unsigned              pos_col, pos_row;
   logic signed [PIX_W-1:0]  last_pix, last_pix2;
   logic signed [HV_W-1:0]   bank0 [MAX_WIDTH];
   logic signed [HV_W-1:0]   bank1 [MAX_WIDTH];
   logic                     bank_swap;
   int                       run_count;

   int fail_count      = 0;
   int pixels_sent     = 0;
   int results_checked = 0;
   int frames_done     = 0;
   int idle_cycles     = 0;
   int stall_tick      = 0;
   int burst_left      = 0;
   bit block_quiet     = 0;
   stall_mode_type stall_mode = STALL_NONE;

   separable_3tap_convolution dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_in    (req_pixel_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_row     (rsp_out_row),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_done  (rsp_frame_done),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #4 clock = ~clock;

   function automatic void reset_model();
      cfg_width  = s3conv_pkg::IMAGE_WIDTH_RESET;
      cfg_height = s3conv_pkg::IMAGE_HEIGHT_RESET;
      cfg_left   = s3conv_pkg::COEF_LEFT_RESET;
      cfg_center = s3conv_pkg::COEF_CENTER_RESET;
      cfg_right  = s3conv_pkg::COEF_RIGHT_RESET;
      pos_col    = 0;
      pos_row    = 0;
      last_pix   = '0;
      last_pix2  = '0;
      bank_swap  = 1'b0;
   endfunction

   function automatic longint tap_sum(longint a, longint b, longint c, longint lo, longint hi);
      longint acc;
      acc = longint'(cfg_left) * a + longint'(cfg_center) * b + longint'(cfg_right) * c
            + (longint'(1) << (FRAC_W - 1));
      acc = acc >>> FRAC_W;
      if (acc < lo) begin
         acc = lo;
      end else if (acc > hi) begin
         acc = hi;
      end
      return acc;
   endfunction

   function automatic void add_result(longint value, int unsigned x, int unsigned r);
      filtered_type t;
      t.pixel = PIX_W'(value);
      t.col   = COL_W'(x);
      t.row   = ROW_W'(r);
      t.last  = 1'b0;
      t.frame = 1'b0;
      expected_pixels.push_back(t);
      run_count++;
   endfunction

   // vertical pass for one finished column, then store the row sum
   function automatic void close_column(int unsigned x, longint hv, int unsigned r, bit last_row);
      longint newer, older;
      newer = bank_swap ? bank1[x] : bank0[x];
      older = bank_swap ? bank0[x] : bank1[x];
      if (r >= 1) begin
         add_result(tap_sum((r >= 2) ? older : newer, newer, hv, OUT_LOW, OUT_HIGH), x, r - 1);
         if (last_row) begin
            add_result(tap_sum(newer, hv, hv, OUT_LOW, OUT_HIGH), x, r);
         end
      end else if (last_row) begin
         add_result(tap_sum(hv, hv, hv, OUT_LOW, OUT_HIGH), x, 0);
      end
      if (bank_swap) begin
         bank0[x] = HV_W'(hv);
      end else begin
         bank1[x] = HV_W'(hv);
      end
   endfunction

   function automatic void filter_pixel(logic signed [PIX_W-1:0] p);
      int unsigned  w, h, c, r;
      bit           row_end, last_row;
      filtered_type t;
      w = cfg_width;
      h = cfg_height;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h == 0) h = 1;
      c = pos_col;
      r = pos_row;
      row_end  = (c + 1 >= w);
      last_row = (r + 1 >= h);
      run_count = 0;
      if (c == 0) begin
         if (row_end) begin
            close_column(0, tap_sum(p, p, p, HSUM_LOW, HSUM_HIGH), r, last_row);
         end
      end else begin
         close_column(c - 1, tap_sum((c == 1) ? last_pix : last_pix2, last_pix, p,
                                     HSUM_LOW, HSUM_HIGH), r, last_row);
         if (row_end) begin
            close_column(c, tap_sum(last_pix, p, p, HSUM_LOW, HSUM_HIGH), r, last_row);
         end
      end
      last_pix2 = last_pix;
      last_pix  = p;
      if (row_end) begin
         pos_col   = 0;
         bank_swap = ~bank_swap;
         pos_row   = last_row ? 0 : r + 1;
      end else begin
         pos_col = c + 1;
      end
      if (run_count > 0) begin
         t = expected_pixels.pop_back();
         t.last = 1'b1;
         if (row_end && last_row) begin
            t.frame = 1'b1;
            frames_done++;
         end
         expected_pixels.push_back(t);
      end
   endfunction

   function automatic void check_field(string field, logic signed [31:0] want,
                                       logic signed [31:0] got);
      if (got !== want) begin
         $error("%s expected %0d actual %0d", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      filtered_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected item: pixel_out %0d out_col %0d out_row %0d",
                   rsp_pixel_out, rsp_out_col, rsp_out_row);
            fail_count++;
         end else begin
            want = expected_pixels.pop_front();
            results_checked++;
            check_field("pixel_out", want.pixel, rsp_pixel_out);
            check_field("out_col", want.col, rsp_out_col);
            check_field("out_row", want.row, rsp_out_row);
            check_field("last_of_run", want.last, rsp_last_of_run);
            check_field("frame_done", want.frame, rsp_frame_done);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no item moved for %0d cycles", idle_cycles);
            $display("status: fail");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      stall_tick++;
      if (stall_tick % 97 == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (stall_tick[3:2] == 2'b11);
      endcase
   end

   task automatic wait_quiet();
      if (!block_quiet) begin
         @(negedge clock);
         req_valid <= 1'b0;
         while (expected_pixels.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
         block_quiet = 1;
      end
   endtask

   task automatic send_pixel(input logic signed [PIX_W-1:0] pix);
      @(negedge clock);
      req_valid    <= 1'b1;
      req_pixel_in <= pix;
      do @(posedge clock); while (req_stall);
      filter_pixel(pix);
      pixels_sent++;
      block_quiet = 0;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(10, 45) : $urandom_range(0, 6))
            @(negedge clock);
      end else begin
         burst_left--;
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      wait_quiet();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         s3conv_pkg::CSR_IMAGE_WIDTH:  cfg_width  = value[IMG_W_W-1:0];
         s3conv_pkg::CSR_IMAGE_HEIGHT: cfg_height = value;
         s3conv_pkg::CSR_COEF_LEFT:    cfg_left   = value;
         s3conv_pkg::CSR_COEF_CENTER:  cfg_center = value;
         s3conv_pkg::CSR_COEF_RIGHT:   cfg_right  = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_size(input int w, input int h);
      write_reg(s3conv_pkg::CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_reg(s3conv_pkg::CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
   endtask

   task automatic set_taps(input logic [CSR_DATA_W-1:0] l, input logic [CSR_DATA_W-1:0] c,
                           input logic [CSR_DATA_W-1:0] r);
      write_reg(s3conv_pkg::CSR_COEF_LEFT, l);
      write_reg(s3conv_pkg::CSR_COEF_CENTER, c);
      write_reg(s3conv_pkg::CSR_COEF_RIGHT, r);
   endtask

   function automatic logic signed [PIX_W-1:0] pick_pixel(pixel_style_type style);
      case (style)
         PIX_SMALL:   return PIX_W'($urandom_range(0, 8191) - 4096);
         PIX_EXTREME: return ($urandom_range(0, 1) == 0) ? 16'sh7fff : 16'sh8000;
         default:     return PIX_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic test_default_taps();
      set_size(2, 2);
      send_pixel(16'sd16384);
      send_pixel(-16'sd16384);
      send_pixel(16'sh7fff);
      send_pixel(16'sh8000);
   endtask

   // zero sizes act as one, so every pixel is a whole frame
   task automatic test_saturating_taps();
      set_size(0, 0);
      set_taps(16'h7fff, 16'h7fff, 16'h7fff);
      send_pixel(16'sh7fff);
      send_pixel(16'sh8000);
      send_pixel(16'sd0);
      set_taps(16'h8000, 16'h8000, 16'h8000);
      send_pixel(16'sh7fff);
      send_pixel(16'sh8000);
      send_pixel(-16'sd1);
   endtask

   task automatic test_small_frames();
      set_size(2, 3);
      set_taps(-16'sd8192, 16'sd24576, -16'sd8192);
      send_pixel(16'sh7fff);
      send_pixel(16'sh8000);
      send_pixel(16'sd1);
      send_pixel(-16'sd1);
      send_pixel(16'sh8000);
      send_pixel(16'sh7fff);
      set_size(1, 3);
      set_taps(16'sd4096, 16'sd8192, 16'sd4096);
      send_pixel(16'sd12345);
      send_pixel(-16'sd23456);
      send_pixel(16'sd32000);
   endtask

   // shrink width and height while the frame is open
   task automatic test_midframe_resize();
      set_size(3, 3);
      repeat (4) send_pixel(pick_pixel(PIX_FULL));
      set_size(1, 2);
      write_reg(s3conv_pkg::CSR_COEF_CENTER, 16'sd16384);
      send_pixel(pick_pixel(PIX_FULL));
   endtask

   task automatic test_tall_frame();
      set_size(1, 65535);
      send_pixel(16'sd20000);
      send_pixel(-16'sd20000);
      write_reg(s3conv_pkg::CSR_IMAGE_HEIGHT, 16'd1);
      send_pixel(16'sd7);
   endtask

   task automatic test_wide_row();
      set_size(40, 2);
      set_taps(CSR_DATA_W'($urandom_range(0, 65535)), CSR_DATA_W'($urandom_range(0, 65535)),
               CSR_DATA_W'($urandom_range(0, 65535)));
      repeat (80) send_pixel(pick_pixel(PIX_FULL));
   endtask

   task automatic test_random_frames();
      int              start, w, h, n, pause_at, frame_no;
      pixel_style_type style;
      start    = pixels_sent;
      frame_no = 0;
      while (pixels_sent - start < RANDOM_PIXELS) begin
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 12);
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 6);
         set_size(w, h);
         if ($urandom_range(0, 2) == 0) begin
            set_taps(CSR_DATA_W'($urandom_range(0, 65535)), CSR_DATA_W'($urandom_range(0, 65535)),
                     CSR_DATA_W'($urandom_range(0, 65535)));
         end else begin
            set_taps(CSR_DATA_W'($urandom_range(0, 12288) - 4096),
                     CSR_DATA_W'($urandom_range(4096, 16384)),
                     CSR_DATA_W'($urandom_range(0, 12288) - 4096));
         end
         n = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
         pause_at = (frame_no == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
         style = pixel_style_type'($urandom_range(0, 2));
         for (int i = 0; i < n; i++) begin
            if (i == pause_at) wait_quiet();
            send_pixel(pick_pixel(($urandom_range(0, 7) == 0) ? PIX_FULL : style));
         end
         frame_no++;
      end
   endtask

   initial begin
      reset_model();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_taps();
      test_saturating_taps();
      test_small_frames();
      test_midframe_resize();
      test_tall_frame();
      test_wide_row();
      test_random_frames();
      wait_quiet();
      $display("checked %0d filtered pixels from %0d input pixels, %0d frames",
               results_checked, pixels_sent, frames_done);
      $display("covered reset taps, saturating taps, unit and zero sizes, mid-frame resize, "
               , "tall frames, a two-row wide frame and random frames");
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
